// ===== rtl/hsv_pkg.sv =====
// Package for the HSV to RGB pixel converter: sector codes, limits and
// the reciprocal constants for the divisions by 60 and by 10000/255.
// No dependencies.
`default_nettype none

package hsv_pkg;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  localparam logic [8:0]  HueMax    = 9'd360;
  localparam logic [8:0]  Hue60     = 9'd60;
  localparam logic [8:0]  Hue120    = 9'd120;
  localparam logic [8:0]  Hue180    = 9'd180;
  localparam logic [8:0]  Hue240    = 9'd240;
  localparam logic [8:0]  Hue300    = 9'd300;
  localparam logic [5:0]  SectorDeg = 6'd60;
  localparam logic [6:0]  PctMax    = 7'd100;
  localparam logic [13:0] OneScaled = 14'd10000;
  localparam logic [7:0]  ChanMax   = 8'd255;

  // floor(q / 15) = (q * RecipFifteen) >> 21 for q below 150001
  localparam logic [17:0] RecipFifteen = 18'd139811;
  // channel = floor(sum * 51 / 2000); the divide by 125 is (q * RecipChan) >> 22
  localparam logic [5:0]  ChanMul   = 6'd51;
  localparam logic [15:0] RecipChan = 16'd33555;

endpackage

`default_nettype wire

// ===== rtl/hsv_to_rgb.sv =====
// HSV to RGB pixel converter, five register stages.
// One transaction per cycle while the output is not stalled.
// Throughput is set by the pipeline: every stage advances when it is empty or
// the stage after it advances, so bubbles close up under an output stall.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data needs none.
// Depends on hsv_pkg.
`default_nettype none

module hsv_to_rgb import hsv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [8:0] hue_degrees_i,
  input  wire logic [6:0] saturation_pct_i,
  input  wire logic [6:0] value_pct_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  // Stage 1: clamp, sector, weight, chroma and offset
  logic [8:0]  h_c;
  logic [6:0]  s_c, vv_c;
  logic [8:0]  off_c;
  sector_e     sec_d;
  logic [5:0]  w_d;
  logic [13:0] c_d, m_d;

  sector_e     sec1_q, sec2_q, sec3_q;
  logic [5:0]  w1_q;
  logic [13:0] c1_q, c2_q, c3_q;
  logic [13:0] m1_q, m2_q, m3_q;

  always_comb begin
    h_c  = (hue_degrees_i > HueMax) ? HueMax : hue_degrees_i;
    s_c  = (saturation_pct_i > PctMax) ? PctMax : saturation_pct_i;
    vv_c = (value_pct_i > PctMax) ? PctMax : value_pct_i;
    if (h_c < Hue60) begin
      sec_d = SEC_RY;
      off_c = h_c;
    end else if (h_c < Hue120) begin
      sec_d = SEC_YG;
      off_c = h_c - Hue60;
    end else if (h_c < Hue180) begin
      sec_d = SEC_GC;
      off_c = h_c - Hue120;
    end else if (h_c < Hue240) begin
      sec_d = SEC_CB;
      off_c = h_c - Hue180;
    end else if (h_c < Hue300) begin
      sec_d = SEC_BM;
      off_c = h_c - Hue240;
    end else begin
      sec_d = SEC_MR;
      off_c = h_c - Hue300;
    end
    w_d = sec_d[0] ? (SectorDeg - off_c[5:0]) : off_c[5:0];
    c_d = 14'(s_c) * 14'(vv_c);
    m_d = 14'(vv_c) * 14'(PctMax - s_c);
  end

  // Stage 2: chroma times weight
  logic [19:0] p2_q, p2_d;
  assign p2_d = 20'(c1_q) * 20'(w1_q);

  // Stage 3: secondary x = floor(p / 60)
  logic [35:0] xp;
  logic [13:0] x3_q, x3_d;
  assign xp   = 36'(p2_q[19:2]) * 36'(RecipFifteen);
  assign x3_d = xp[34:21];

  // Stage 4: place components, add offset, scale by 51/16
  logic [2:0][13:0] comp;
  logic [2:0][19:0] scaled;
  logic [2:0][14:0] a4_q, a4_d;

  always_comb begin
    comp = '0;
    unique case (sec3_q)
      SEC_RY: begin
        comp[0] = c3_q; comp[1] = x3_q;
      end
      SEC_YG: begin
        comp[0] = x3_q; comp[1] = c3_q;
      end
      SEC_GC: begin
        comp[1] = c3_q; comp[2] = x3_q;
      end
      SEC_CB: begin
        comp[1] = x3_q; comp[2] = c3_q;
      end
      SEC_BM: begin
        comp[0] = x3_q; comp[2] = c3_q;
      end
      SEC_MR: begin
        comp[0] = c3_q; comp[2] = x3_q;
      end
      default: comp = '0;
    endcase
    for (int i = 0; i < 3; i++) begin
      scaled[i] = 20'(comp[i] + m3_q) * 20'(ChanMul);
      a4_d[i]   = scaled[i][18:4];
    end
  end

  // Stage 5: divide by 125 and clamp
  logic [2:0][30:0] cp;
  logic [2:0][7:0]  ch5_q, ch5_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cp[i]    = 31'(a4_q[i]) * 31'(RecipChan);
      ch5_d[i] = (cp[i][30:22] > 9'(ChanMax)) ? ChanMax : cp[i][29:22];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      sec1_q <= sec_d;
      w1_q   <= w_d;
      c1_q   <= c_d;
      m1_q   <= m_d;
    end
    if (en2 && v1_q) begin
      sec2_q <= sec1_q;
      c2_q   <= c1_q;
      m2_q   <= m1_q;
      p2_q   <= p2_d;
    end
    if (en3 && v2_q) begin
      sec3_q <= sec2_q;
      c3_q   <= c2_q;
      m3_q   <= m2_q;
      x3_q   <= x3_d;
    end
    if (en4 && v3_q) begin
      a4_q <= a4_d;
    end
    if (en5 && v4_q) begin
      ch5_q <= ch5_d;
    end
  end

  assign out_valid_o = v5_q;
  assign red_o       = ch5_q[0];
  assign green_o     = ch5_q[1];
  assign blue_o      = ch5_q[2];

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_chroma_within_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (c1_q + m1_q <= OneScaled))
    else $error("chroma plus offset exceeds one");

  a_secondary_le_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (x3_q <= c3_q))
    else $error("secondary component exceeds chroma");

endmodule

`default_nettype wire

// ===== sim/hsv_to_rgb_checker.sv =====
// Checker for the HSV to RGB pixel converter: watches both channels, predicts
// each pixel and compares it with the converter's output, in order.
// Depends on hsv_pkg for the sector codes and limits.
`timescale 1ns / 1ps

module hsv_to_rgb_checker import hsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [8:0] hue_degrees_i,
  input  logic [6:0] saturation_pct_i,
  input  logic [6:0] value_pct_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output int         fail_count_o,
  output int         outstanding_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  pixel_t expected_pixels[$];
  int     errors = 0;

  function automatic logic [7:0] to_channel(int unsigned comp, int unsigned offset);
    int unsigned level;
    level = ((comp + offset) * int'(ChanMax)) / int'(OneScaled);
    if (level > int'(ChanMax)) level = int'(ChanMax);
    return level[7:0];
  endfunction

  function automatic pixel_t predict_pixel(logic [8:0] hue, logic [6:0] sat, logic [6:0] val);
    int unsigned h, sp, vp, v, c, x, m, hm, d;
    int unsigned comp_r, comp_g, comp_b;
    sector_e     sector;
    pixel_t      px;
    h  = (hue > HueMax) ? int'(HueMax) : int'(hue);
    sp = (sat > PctMax) ? int'(PctMax) : int'(sat);
    vp = (val > PctMax) ? int'(PctMax) : int'(val);
    v  = vp * 100;
    c  = sp * vp;
    hm = h % (2 * int'(SectorDeg));
    d  = (hm >= int'(SectorDeg)) ? hm - int'(SectorDeg) : int'(SectorDeg) - hm;
    x  = (c * (int'(SectorDeg) - d)) / int'(SectorDeg);
    m  = v - c;
    if (h < int'(Hue60))       sector = SEC_RY;
    else if (h < int'(Hue120)) sector = SEC_YG;
    else if (h < int'(Hue180)) sector = SEC_GC;
    else if (h < int'(Hue240)) sector = SEC_CB;
    else if (h < int'(Hue300)) sector = SEC_BM;
    else                       sector = SEC_MR;
    case (sector)
      SEC_RY: begin comp_r = c; comp_g = x; comp_b = 0; end
      SEC_YG: begin comp_r = x; comp_g = c; comp_b = 0; end
      SEC_GC: begin comp_r = 0; comp_g = c; comp_b = x; end
      SEC_CB: begin comp_r = 0; comp_g = x; comp_b = c; end
      SEC_BM: begin comp_r = x; comp_g = 0; comp_b = c; end
      default: begin comp_r = c; comp_g = 0; comp_b = x; end
    endcase
    px.red   = to_channel(comp_r, m);
    px.green = to_channel(comp_g, m);
    px.blue  = to_channel(comp_b, m);
    return px;
  endfunction

  task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        expected_pixels.push_back(predict_pixel(hue_degrees_i, saturation_pct_i, value_pct_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %0d/%0d/%0d",
                   $time, red_i, green_i, blue_i);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          check_channel("red", want.red, red_i);
          check_channel("green", want.green, green_i);
          check_channel("blue", want.blue, blue_i);
        end
      end
    end
    fail_count_o  <= errors;
    outstanding_o <= expected_pixels.size();
  end

endmodule

// ===== sim/tb_hsv_to_rgb.sv =====
// Testbench top for the HSV to RGB pixel converter: clock, reset, directed and
// random pixel stimulus, output stalls and the verdict.
// Depends on hsv_pkg, hsv_to_rgb and hsv_to_rgb_checker.
`timescale 1ns / 1ps

module tb_hsv_to_rgb import hsv_pkg::*;;

  localparam int RandomPixels = 1750;
  localparam int CycleLimit   = 100000;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic [8:0] hue_degrees_i    = '0;
  logic [6:0] saturation_pct_i = '0;
  logic [6:0] value_pct_i      = '0;
  logic       out_stall_i      = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] red_o, green_o, blue_o;
  int         fail_count, outstanding;
  int         cycle_count = 0;
  int         rx_cycle    = 0;

  always #5 clk_i = ~clk_i;

  hsv_to_rgb uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .hue_degrees_i, .saturation_pct_i,
    .value_pct_i, .out_valid_o, .out_stall_i, .red_o, .green_o, .blue_o
  );

  hsv_to_rgb_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .hue_degrees_i,
    .saturation_pct_i, .value_pct_i, .out_valid_i(out_valid_o), .out_stall_i,
    .red_i(red_o), .green_i(green_o), .blue_i(blue_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // hold off for a long stretch, then a stretch with no stalls
  initial begin
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle >= 300 && rx_cycle < 500) out_stall_i <= 1'b1;
      else if (rx_cycle >= 1000 && rx_cycle < 1500) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(99) < 9);
    end
  end

  task automatic send_pixel(logic [8:0] hue, logic [6:0] sat, logic [6:0] val, bit may_idle);
    if (may_idle && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    hue_degrees_i    <= hue;
    saturation_pct_i <= sat;
    value_pct_i      <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [8:0] hue;
    logic [6:0] sat, val;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(9'd0, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd60, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd120, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd180, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd240, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd300, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd359, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd360, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd361, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd511, 7'd127, 7'd127, 1'b0);
    send_pixel(9'd0, 7'd0, 7'd0, 1'b0);
    send_pixel(9'd0, 7'd0, 7'd100, 1'b0);
    send_pixel(9'd30, 7'd50, 7'd75, 1'b0);
    send_pixel(9'd90, 7'd50, 7'd75, 1'b0);
    send_pixel(9'd150, 7'd50, 7'd75, 1'b0);
    send_pixel(9'd210, 7'd50, 7'd75, 1'b0);
    send_pixel(9'd270, 7'd50, 7'd75, 1'b0);
    send_pixel(9'd330, 7'd50, 7'd75, 1'b0);
    send_pixel(9'd1, 7'd1, 7'd1, 1'b0);
    send_pixel(9'd119, 7'd100, 7'd100, 1'b0);
    send_pixel(9'd45, 7'd127, 7'd80, 1'b0);
    send_pixel(9'd200, 7'd60, 7'd127, 1'b0);
    send_pixel(9'd256, 7'd64, 7'd64, 1'b0);
    drain_pixels();

    for (int i = 0; i < RandomPixels; i++) begin
      if (i == 600) drain_pixels();
      if ($urandom_range(99) < 20) begin
        hue = 9'($urandom);
        sat = 7'($urandom);
        val = 7'($urandom);
      end else begin
        hue = 9'($urandom_range(360));
        sat = 7'($urandom_range(100));
        val = 7'($urandom_range(100));
      end
      send_pixel(hue, sat, val, !(i >= 900 && i < 1300));
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
